### rtl/csu_pkg.sv
// Package for the C string unescape decoder: decode modes, character codes,
// queue entry type and small decode helper functions. No dependencies.
package csu_pkg;

  // Decode mode, one-hot
  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_ESCAPE = 4'b0010,
    MODE_HEX    = 4'b0100,
    MODE_OCTAL  = 4'b1000
  } mode_t;

  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_X      = 8'h78;
  localparam logic [7:0] ESC_CODE   = 8'h1B;
  localparam logic [7:0] SAT_MAX    = 8'hFF;

  // Octal digit count at which a run closes
  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

  // One queue entry: the one or two result bytes caused by one input word
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
    logic       fin;
  } entry_t;

  // Hex digit: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9")      r = {1'b1, 4'(c - "0")};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    return r;
  endfunction

  // Single-letter escape: {hit, control code}
  function automatic logic [8:0] esc_letter(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      "a":     r = {1'b1, 8'h07};
      "b":     r = {1'b1, 8'h08};
      "e":     r = {1'b1, ESC_CODE};
      "f":     r = {1'b1, 8'h0C};
      "n":     r = {1'b1, 8'h0A};
      "r":     r = {1'b1, 8'h0D};
      "t":     r = {1'b1, 8'h09};
      "v":     r = {1'b1, 8'h0B};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Clamp a 9-bit value to a byte
  function automatic logic [7:0] sat9(input logic [8:0] v);
    return (v > 9'({1'b0, SAT_MAX})) ? SAT_MAX : v[7:0];
  endfunction

endpackage

### rtl/csu_if.sv
// Channel interfaces for the unescape decoder: raw byte input and decoded
// byte output, each with valid/ready. Depends on nothing.
interface csu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source  (output valid, in_byte, is_final, input ready);
  modport sink    (input valid, in_byte, is_final, output ready);
  modport monitor (input valid, ready, in_byte, is_final);
endinterface

interface csu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  modport source  (output valid, out_byte, run_end, string_end, input ready);
  modport sink    (input valid, out_byte, run_end, string_end, output ready);
  modport monitor (input valid, ready, out_byte, run_end, string_end);
endinterface

### rtl/csu_front.sv
// Front end: accepts raw words, runs the escape decode state and pushes the
// resulting one or two bytes into the queue. Depends on csu_pkg, csu_if.
module csu_front import csu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  csu_in_if.sink       in_ch,
  input  logic         q_full,
  output logic         push,
  output entry_t       push_entry
);

  mode_t      mode_r, mode_nxt;
  logic [8:0] acc_r, acc_nxt;
  logic       hex_seen_r, hex_seen_nxt;
  logic [1:0] oct_cnt_r, oct_cnt_nxt;

  logic [7:0]  b;
  logic        fin;
  logic        accept;
  logic [1:0]  n_res;
  logic [7:0]  byte0, byte1;
  logic        plain_emit;
  logic [4:0]  hex_d;
  logic [8:0]  esc_l;
  logic        is_oct;
  logic [12:0] hex_shift;
  logic [8:0]  hex_acc;
  logic [8:0]  oct_acc;

  assign b      = in_ch.in_byte;
  assign fin    = in_ch.is_final;
  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && !q_full;

  assign plain_emit = !(b == CHR_BSLASH && !fin);
  assign hex_d      = hex_digit(b);
  assign esc_l      = esc_letter(b);
  assign is_oct     = (b >= "0") && (b <= "7");
  assign hex_shift  = {acc_r, 4'b0000} | {9'd0, hex_d[3:0]};
  assign hex_acc    = (hex_shift > 13'({5'd0, SAT_MAX})) ? {1'b0, SAT_MAX} : hex_shift[8:0];
  assign oct_acc    = {acc_r[5:0], b[2:0]};

  // Decode of one word against the current mode
  always_comb begin
    mode_nxt     = mode_r;
    acc_nxt      = acc_r;
    hex_seen_nxt = hex_seen_r;
    oct_cnt_nxt  = oct_cnt_r;
    n_res        = 2'd0;
    byte0        = b;
    byte1        = b;
    unique case (mode_r)
      MODE_NORMAL: begin
        if (plain_emit) n_res = 2'd1;
        else            mode_nxt = MODE_ESCAPE;
      end
      MODE_ESCAPE: begin
        mode_nxt = MODE_NORMAL;
        if (esc_l[8]) begin
          n_res = 2'd1;
          byte0 = esc_l[7:0];
        end else if (b == CHR_X) begin
          acc_nxt      = 9'd0;
          hex_seen_nxt = 1'b0;
          if (fin) begin
            n_res = 2'd1;
            byte0 = CHR_X;
          end else begin
            mode_nxt = MODE_HEX;
          end
        end else if (is_oct) begin
          acc_nxt     = {6'd0, b[2:0]};
          oct_cnt_nxt = 2'd1;
          if (fin) begin
            n_res = 2'd1;
            byte0 = {5'd0, b[2:0]};
          end else begin
            mode_nxt = MODE_OCTAL;
          end
        end else begin
          n_res = 2'd1;
        end
      end
      MODE_HEX: begin
        if (hex_d[4]) begin
          acc_nxt      = hex_acc;
          hex_seen_nxt = 1'b1;
          if (fin) begin
            n_res    = 2'd1;
            byte0    = hex_acc[7:0];
            mode_nxt = MODE_NORMAL;
          end
        end else begin
          // run ends: pending value, then the word as a normal byte unless it is a backslash that opens an escape
          byte0    = hex_seen_r ? acc_r[7:0] : CHR_X;
          mode_nxt = MODE_NORMAL;
          if (plain_emit) begin
            n_res = 2'd2;
          end else begin
            n_res    = 2'd1;
            mode_nxt = MODE_ESCAPE;
          end
        end
      end
      MODE_OCTAL: begin
        if (is_oct && oct_cnt_r < OCT_MAX_DIGITS) begin
          acc_nxt     = oct_acc;
          oct_cnt_nxt = oct_cnt_r + 2'd1;
          if (fin || oct_cnt_nxt >= OCT_MAX_DIGITS) begin
            n_res    = 2'd1;
            byte0    = sat9(oct_acc);
            mode_nxt = MODE_NORMAL;
          end
        end else begin
          byte0    = sat9(acc_r);
          mode_nxt = MODE_NORMAL;
          if (plain_emit) begin
            n_res = 2'd2;
          end else begin
            n_res    = 2'd1;
            mode_nxt = MODE_ESCAPE;
          end
        end
      end
      default: mode_nxt = MODE_NORMAL;
    endcase
    // end of string returns everything to reset
    if (fin) begin
      mode_nxt     = MODE_NORMAL;
      acc_nxt      = 9'd0;
      hex_seen_nxt = 1'b0;
      oct_cnt_nxt  = 2'd0;
    end
  end

  // Decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NORMAL;
      acc_r      <= 9'd0;
      hex_seen_r <= 1'b0;
      oct_cnt_r  <= 2'd0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      acc_r      <= acc_nxt;
      hex_seen_r <= hex_seen_nxt;
      oct_cnt_r  <= oct_cnt_nxt;
    end
  end

  assign push             = accept && (n_res != 2'd0);
  assign push_entry.byte0 = byte0;
  assign push_entry.byte1 = byte1;
  assign push_entry.two   = (n_res == 2'd2);
  assign push_entry.fin   = fin;

endmodule

### rtl/csu_queue.sv
// Short queue of decoded entries between front and back end.
// Depends on csu_pkg.
module csu_queue import csu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

### rtl/csu_back.sv
// Back end: takes queue entries and sends their bytes one word per cycle,
// unless the output stalls, through the output register. Depends on csu_pkg, csu_if.
module csu_back import csu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  entry_t   entry,
  input  logic     entry_valid,
  output logic     pop,
  csu_out_if.source out_ch
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       run_end_r;
  logic       string_end_r;
  logic       phase_r;
  logic       load;
  logic       first_half;

  assign load       = entry_valid && (!out_valid_r || out_ch.ready);
  assign first_half = entry.two && !phase_r;
  assign pop        = load && !first_half;

  // Output register valid and second-byte phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      phase_r     <= first_half;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (first_half) begin
        out_byte_r   <= entry.byte0;
        run_end_r    <= 1'b0;
        string_end_r <= 1'b0;
      end else begin
        out_byte_r   <= entry.two ? entry.byte1 : entry.byte0;
        run_end_r    <= 1'b1;
        string_end_r <= entry.fin;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.run_end    = run_end_r;
  assign out_ch.string_end = string_end_r;

endmodule

### rtl/c_string_unescape_decoder.sv
// C string unescape decoder: one raw byte per input word, one decoded byte per output word.
// Path: an accepted word is registered in the queue, then in the output register.
// Throughput: one input word per cycle; a word that ends a hex or octal run
// and carries a byte of its own gives two output words in turn; input held off while queue full.
// Reset (rst_n low, synchronous): decode state to normal, queue and output register empty.
// Depends on csu_pkg, csu_if, csu_front, csu_queue, csu_back.
module c_string_unescape_decoder import csu_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  csu_in_if.sink     in_ch,
  csu_out_if.source  out_ch
);

  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  entry_t pop_entry;
  logic   q_not_empty;

  csu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  csu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_not_empty)
  );

  csu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry       (pop_entry),
    .entry_valid (q_not_empty),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

### rtl/csu_checker.sv
// Port-level checks for the unescape decoder, bound to the top level.
// Depends on csu_if and c_string_unescape_decoder.
module csu_checker (
  input logic       clk,
  input logic       rst_n,
  csu_in_if.sink    in_ch,
  csu_out_if.source out_ch
);

  // Stalled output word keeps valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("output word dropped while stalled");

  // Stalled output word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      $stable(out_ch.out_byte) && $stable(out_ch.run_end) && $stable(out_ch.string_end))
    else $error("output payload changed while stalled");

  // Input is only held off when the queue is full, so a result must be waiting
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no result pending");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

bind c_string_unescape_decoder csu_checker u_csu_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
